FILE: src/wsd_pkg.sv
// ----------------------------------------------------------------------------
// wsd_pkg
// Shared types and codes for the WebSocket frame deframer.
// ----------------------------------------------------------------------------
package wsd_pkg;

  localparam logic [1:0] LINK_BYTE   = 2'd0;
  localparam logic [1:0] LINK_CLOSED = 2'd1;
  localparam logic [1:0] LINK_FAULT  = 2'd2;

  localparam logic [1:0] KIND_HEADER  = 2'd0;
  localparam logic [1:0] KIND_PAYLOAD = 2'd1;
  localparam logic [1:0] KIND_EMPTY   = 2'd2;
  localparam logic [1:0] KIND_ERROR   = 2'd3;

  localparam logic [3:0] ERR_NONE        = 4'd0;
  localparam logic [3:0] ERR_RSV         = 4'd1;
  localparam logic [3:0] ERR_FRAG_CTRL   = 4'd2;
  localparam logic [3:0] ERR_IN_FRAGMENT = 4'd3;
  localparam logic [3:0] ERR_NO_START    = 4'd4;
  localparam logic [3:0] ERR_UNMASKED    = 4'd5;
  localparam logic [3:0] ERR_CTRL_LONG   = 4'd6;
  localparam logic [3:0] ERR_RSV_OPCODE  = 4'd7;
  localparam logic [3:0] ERR_CLOSED      = 4'd8;
  localparam logic [3:0] ERR_FAULT       = 4'd9;

  localparam logic [7:0] RSV_BITS    = 8'h70;
  localparam logic [7:0] OPCODE_BITS = 8'h0f;
  localparam logic [7:0] TOP_BIT     = 8'h80;

  localparam logic [6:0] LEN_MAX_SHORT = 7'd125;
  localparam logic [6:0] LEN_EXT16     = 7'd126;

  localparam logic [2:0] REG_SERVER_MODE = 3'd0;

  // queue entry handed from front to back
  typedef struct packed {
    logic [1:0] link;
    logic [7:0] data;
  } wsd_item_t;

  typedef struct packed {
    logic      valid;
    wsd_item_t item;
  } wsd_queue_t;

  typedef struct packed {
    logic       stopped;
    logic [2:0] phase;
  } wsd_status_t;

endpackage

FILE: src/wsd_if.sv
// ----------------------------------------------------------------------------
// wsd_if
// Valid/ready channels for received bytes and for deframer results.
// ----------------------------------------------------------------------------
interface wsd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] byte_in;
  logic [1:0] link_status;
  modport source (output valid, output byte_in, output link_status, input ready);
  modport sink (input valid, input byte_in, input link_status, output ready);
endinterface

interface wsd_out_if;
  logic       valid;
  logic       ready;
  logic [1:0] kind;
  logic [7:0] payload_byte;
  logic [3:0] frame_opcode;
  logic       frame_fin;
  logic       last_of_frame;
  logic [3:0] error_code;
  modport source (output valid, output kind, output payload_byte, output frame_opcode,
                  output frame_fin, output last_of_frame, output error_code, input ready);
  modport sink (input valid, input kind, input payload_byte, input frame_opcode,
                input frame_fin, input last_of_frame, input error_code, output ready);
endinterface

FILE: src/wsd_front.sv
// ----------------------------------------------------------------------------
// wsd_front
// Accept bytes, fold link status into byte/closed/fault, queue two deep.
// ----------------------------------------------------------------------------
module wsd_front import wsd_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       in_valid,
  output logic       in_ready,
  input  logic [7:0] in_byte,
  input  logic [1:0] in_link,
  output wsd_queue_t q,
  input  logic       q_pop
);

  wsd_item_t  mem [2];
  logic       wr_ptr;
  logic       rd_ptr;
  logic [1:0] count;
  logic       push;
  wsd_item_t  cls;

  // link status three counts as a read fault
  always_comb begin
    cls.data = in_byte;
    case (in_link)
      LINK_BYTE:   cls.link = LINK_BYTE;
      LINK_CLOSED: cls.link = LINK_CLOSED;
      default:     cls.link = LINK_FAULT;
    endcase
  end

  assign in_ready = (count != 2'd2);
  assign push     = in_valid && in_ready;
  assign q.valid  = (count != 2'd0);
  assign q.item   = mem[rd_ptr];

  always_ff @(posedge clk) begin
    if (push) begin
      mem[wr_ptr] <= cls;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= 1'b0;
      rd_ptr <= 1'b0;
      count  <= 2'd0;
    end else begin
      if (push) wr_ptr <= ~wr_ptr;
      if (q_pop) rd_ptr <= ~rd_ptr;
      count <= count + {1'b0, push} - {1'b0, q_pop};
    end
  end

endmodule

FILE: src/wsd_back.sv
// ----------------------------------------------------------------------------
// wsd_back
// Frame parser: walk header, length, key and payload; register the result.
// ----------------------------------------------------------------------------
module wsd_back import wsd_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        server_mode,
  input  wsd_queue_t  q,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [1:0]  out_kind,
  output logic [7:0]  out_payload,
  output logic [3:0]  out_opcode,
  output logic        out_fin,
  output logic        out_last,
  output logic [3:0]  out_code,
  output wsd_status_t status
);

  localparam logic [2:0] PH_HEADER  = 3'd0;
  localparam logic [2:0] PH_LEN     = 3'd1;
  localparam logic [2:0] PH_EXT     = 3'd2;
  localparam logic [2:0] PH_MASK    = 3'd3;
  localparam logic [2:0] PH_PAYLOAD = 3'd4;

  logic [2:0]  phase, phase_next;
  logic        fin, fin_next;
  logic [3:0]  cur_op, cur_op_next;
  logic [3:0]  frag_op, frag_op_next;
  logic [63:0] rem, rem_next;
  logic [3:0]  ebl, ebl_next;
  logic [31:0] mkey, mkey_next;
  logic [1:0]  midx, midx_next;
  logic        stopped, stopped_next;

  logic        emit;
  logic [1:0]  r_kind;
  logic [7:0]  r_pay;
  logic        r_last;
  logic [3:0]  r_code;
  logic        ldone;
  logic [7:0]  b;
  logic [3:0]  op;
  logic [6:0]  len;
  logic [7:0]  kbyte;

  assign q_pop  = q.valid && (!out_valid || out_ready);
  assign b      = q.item.data;
  assign op     = b[3:0] & OPCODE_BITS[3:0];
  assign len    = b[6:0];
  assign status = '{stopped: stopped, phase: phase};

  always_comb begin
    case (midx)
      2'd0:    kbyte = mkey[31:24];
      2'd1:    kbyte = mkey[23:16];
      2'd2:    kbyte = mkey[15:8];
      default: kbyte = mkey[7:0];
    endcase
  end

  always_comb begin
    phase_next   = phase;
    fin_next     = fin;
    cur_op_next  = cur_op;
    frag_op_next = frag_op;
    rem_next     = rem;
    ebl_next     = ebl;
    mkey_next    = mkey;
    midx_next    = midx;
    stopped_next = stopped;
    emit   = 1'b0;
    r_kind = KIND_HEADER;
    r_pay  = 8'd0;
    r_last = 1'b0;
    r_code = ERR_NONE;
    ldone  = 1'b0;
    if (q_pop && !stopped) begin
      emit = 1'b1;
      if (q.item.link == LINK_CLOSED) begin
        r_kind = KIND_ERROR;
        r_code = ERR_CLOSED;
      end else if (q.item.link != LINK_BYTE) begin
        r_kind = KIND_ERROR;
        r_code = ERR_FAULT;
      end else begin
        case (phase)
          PH_LEN: begin
            if (((b & TOP_BIT) == 8'd0) && server_mode) begin
              r_kind = KIND_ERROR;
              r_code = ERR_UNMASKED;
            end else if (len > LEN_MAX_SHORT && cur_op[3]) begin
              r_kind = KIND_ERROR;
              r_code = ERR_CTRL_LONG;
            end else if (cur_op inside {[4'd3:4'd7], [4'd11:4'd15]}) begin
              r_kind = KIND_ERROR;
              r_code = ERR_RSV_OPCODE;
            end else if (len <= LEN_MAX_SHORT) begin
              rem_next = {57'd0, len};
              ldone    = 1'b1;
            end else begin
              rem_next   = 64'd0;
              ebl_next   = (len == LEN_EXT16) ? 4'd2 : 4'd8;
              phase_next = PH_EXT;
            end
          end
          PH_EXT: begin
            rem_next = {rem[55:0], b};
            ebl_next = ebl - 4'd1;
            if (ebl_next == 4'd0) ldone = 1'b1;
          end
          PH_MASK: begin
            mkey_next = {mkey[23:0], b};
            ebl_next  = ebl - 4'd1;
            if (ebl_next == 4'd0) begin
              if (rem != 64'd0) begin
                phase_next = PH_PAYLOAD;
                midx_next  = 2'd0;
              end else begin
                phase_next = PH_HEADER;
                r_kind     = KIND_EMPTY;
                r_last     = 1'b1;
              end
            end
          end
          PH_PAYLOAD: begin
            r_kind    = KIND_PAYLOAD;
            r_pay     = server_mode ? (b ^ kbyte) : b;
            midx_next = midx + 2'd1;
            rem_next  = rem - 64'd1;
            r_last    = (rem_next == 64'd0);
            if (r_last) phase_next = PH_HEADER;
          end
          default: begin
            fin_next = b[7];
            if ((b & RSV_BITS) != 8'd0) begin
              r_kind = KIND_ERROR;
              r_code = ERR_RSV;
            end else if (!fin_next && op[3]) begin
              r_kind = KIND_ERROR;
              r_code = ERR_FRAG_CTRL;
            end else if (op != 4'd0) begin
              if (frag_op != 4'd0 && (!fin_next || !op[3])) begin
                r_kind = KIND_ERROR;
                r_code = ERR_IN_FRAGMENT;
              end else begin
                if (!fin_next) frag_op_next = op;
                cur_op_next = op;
                phase_next  = PH_LEN;
              end
            end else if (frag_op == 4'd0) begin
              r_kind = KIND_ERROR;
              r_code = ERR_NO_START;
            end else begin
              cur_op_next = frag_op;
              if (fin_next) frag_op_next = 4'd0;
              phase_next = PH_LEN;
            end
          end
        endcase
      end
      // length known: read the key, start payload, or finish an empty frame
      if (ldone) begin
        if (server_mode) begin
          phase_next = PH_MASK;
          ebl_next   = 4'd4;
        end else if (rem_next != 64'd0) begin
          phase_next = PH_PAYLOAD;
          midx_next  = 2'd0;
        end else begin
          phase_next = PH_HEADER;
          r_kind     = KIND_EMPTY;
          r_last     = 1'b1;
        end
      end
      if (r_kind == KIND_ERROR) stopped_next = 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      phase     <= PH_HEADER;
      fin       <= 1'b0;
      cur_op    <= 4'd0;
      frag_op   <= 4'd0;
      rem       <= 64'd0;
      ebl       <= 4'd0;
      mkey      <= 32'd0;
      midx      <= 2'd0;
      stopped   <= 1'b0;
      out_valid <= 1'b0;
    end else begin
      phase   <= phase_next;
      fin     <= fin_next;
      cur_op  <= cur_op_next;
      frag_op <= frag_op_next;
      rem     <= rem_next;
      ebl     <= ebl_next;
      mkey    <= mkey_next;
      midx    <= midx_next;
      stopped <= stopped_next;
      if (emit) out_valid <= 1'b1;
      else if (out_ready) out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind    <= r_kind;
      out_payload <= r_pay;
      out_opcode  <= cur_op_next;
      out_fin     <= fin_next;
      out_last    <= r_last;
      out_code    <= r_code;
    end
  end

endmodule

FILE: src/websocket_frame_deframer_core.sv
// ----------------------------------------------------------------------------
// websocket_frame_deframer_core
// Receive-side WebSocket frame parser with APB configuration.
// ----------------------------------------------------------------------------
// Feed received bytes one per transaction; every byte yields one result
// transaction (header byte, payload byte, empty frame done, or error) until the
// first error, after which bytes are still taken but produce nothing. The block
// sustains one byte per clock while the receiver takes each result: a byte is
// written into the two-entry queue at the edge that accepts it, and the parser
// step then loads its result into the output register. The throughput is set
// by the combinational parser step, whose widest path is the 64-bit length
// decrement and zero test. Set server_mode at address 0 while idle.
module websocket_frame_deframer_core import wsd_pkg::*; (
  input  logic          clk,
  input  logic          rst,
  wsd_in_if.sink        in_ch,
  wsd_out_if.source     out_ch,
  input  logic          psel,
  input  logic          penable,
  input  logic          pwrite,
  input  logic [2:0]    paddr,
  input  logic [31:0]   pwdata,
  output logic [31:0]   prdata,
  output logic          pready
);

  logic        server_mode;
  wsd_queue_t  q;
  logic        q_pop;
  wsd_status_t status;

  // Register file: one bit, written on the access phase.
  assign pready = 1'b1;
  assign prdata = (paddr == REG_SERVER_MODE) ? {31'd0, server_mode} : 32'd0;

  always_ff @(posedge clk) begin
    if (rst) begin
      server_mode <= 1'b0;
    end else if (psel && penable && pwrite && paddr == REG_SERVER_MODE) begin
      server_mode <= pwdata[0];
    end
  end

  // Front: take each transaction and hold it in the queue.
  wsd_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_ch.valid),
    .in_ready (in_ch.ready),
    .in_byte  (in_ch.byte_in),
    .in_link  (in_ch.link_status),
    .q        (q),
    .q_pop    (q_pop)
  );

  // Back: advance the frame state and drive the result register.
  wsd_back u_back (
    .clk         (clk),
    .rst         (rst),
    .server_mode (server_mode),
    .q           (q),
    .q_pop       (q_pop),
    .out_valid   (out_ch.valid),
    .out_ready   (out_ch.ready),
    .out_kind    (out_ch.kind),
    .out_payload (out_ch.payload_byte),
    .out_opcode  (out_ch.frame_opcode),
    .out_fin     (out_ch.frame_fin),
    .out_last    (out_ch.last_of_frame),
    .out_code    (out_ch.error_code),
    .status      (status)
  );

`ifndef SYNTH
  // Once stopped, stay stopped.
  a_stop_sticky: assert property (@(posedge clk) disable iff (rst)
    status.stopped |=> status.stopped)
    else $error("deframer left the stopped state");

  // An error result always carries a nonzero code.
  a_err_code: assert property (@(posedge clk) disable iff (rst)
    out_ch.valid && out_ch.kind == KIND_ERROR |-> out_ch.error_code != ERR_NONE)
    else $error("error result without code");

  // No new result appears once stopped.
  a_no_emit_stopped: assert property (@(posedge clk) disable iff (rst)
    $past(status.stopped) && status.stopped && !$past(out_ch.valid) |-> !out_ch.valid)
    else $error("result after stop");

  // A stop is always announced by an error result.
  a_stop_reported: assert property (@(posedge clk) disable iff (rst)
    $rose(status.stopped) |-> out_ch.valid && out_ch.kind == KIND_ERROR)
    else $error("stop without error result");
`endif

endmodule

FILE: dv/tb_top.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the WebSocket frame deframer. It feeds well-formed
// frame streams in client and server mode, predicts each result transaction
// from its own parser model and ends every run with one protocol or link
// error, after which the block must go silent.
// ----------------------------------------------------------------------------
module tb_top;
  import wsd_pkg::*;

  // Parser phases of the bench's own model.
  localparam logic [2:0] ST_HEADER  = 3'd0;
  localparam logic [2:0] ST_LEN     = 3'd1;
  localparam logic [2:0] ST_EXT     = 3'd2;
  localparam logic [2:0] ST_KEY     = 3'd3;
  localparam logic [2:0] ST_PAYLOAD = 3'd4;

  localparam logic [3:0] OP_CONT   = 4'd0;
  localparam logic [3:0] OP_TEXT   = 4'd1;
  localparam logic [3:0] OP_BINARY = 4'd2;
  localparam logic [3:0] OP_CLOSE  = 4'd8;
  localparam logic [3:0] OP_PING   = 4'd9;

  localparam logic [6:0] LEN_EXT64 = 7'd127;

  typedef struct packed {
    logic [1:0] kind;
    logic [7:0] pbyte;
    logic [3:0] opcode;
    logic       fin;
    logic       last;
    logic [3:0] code;
  } deframe_res_t;

  logic        clk;
  logic        rst;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  wsd_in_if  in_if ();
  wsd_out_if out_if ();

  websocket_frame_deframer_core uut (
    .clk     (clk),
    .rst     (rst),
    .in_ch   (in_if),
    .out_ch  (out_if),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Stimulus queue, expected results and bookkeeping.
  wsd_item_t    byte_queue[$];
  deframe_res_t expected_res[$];
  int           err_count;
  bit           idle_on;
  bit           server_cfg;
  int           send_gap;
  int           recv_stall;

  // Model state of the parser.
  logic [2:0]  m_phase;
  logic        m_fin;
  logic [3:0]  m_op;
  logic [3:0]  m_frag_op;
  logic [63:0] m_remain;
  logic [3:0]  m_ext_left;
  logic [31:0] m_key;
  logic [1:0]  m_key_idx;
  logic        m_stopped;

  always #2 clk = ~clk;

  function automatic int rand_gap();
    int r;
    r = $urandom_range(0, 99);
    if (r < 60) return 0;
    if (r < 93) return $urandom_range(1, 3);
    return $urandom_range(10, 40);
  endfunction

  task automatic report(input string what, input int exp_v, input int got_v);
    $display("MISMATCH %s: expected %0d got %0d at %0t", what, exp_v, got_v, $realtime);
    err_count++;
  endtask

  // Build one result and record it as expected.
  task automatic push_res(input logic [1:0] kind, input logic [7:0] pb,
                          input logic last, input logic [3:0] code);
    deframe_res_t r;
    r.kind   = kind;
    r.pbyte  = pb;
    r.opcode = m_op;
    r.fin    = m_fin;
    r.last   = last;
    r.code   = code;
    expected_res.push_back(r);
  endtask

  task automatic model_fail(input logic [3:0] code);
    m_stopped = 1'b1;
    push_res(KIND_ERROR, 8'h00, 1'b0, code);
  endtask

  // Length known: read the key in server mode, else start payload or finish.
  task automatic model_len_done();
    if (server_cfg) begin
      m_phase    = ST_KEY;
      m_ext_left = 4'd4;
      push_res(KIND_HEADER, 8'h00, 1'b0, ERR_NONE);
    end else if (m_remain != 64'd0) begin
      m_phase   = ST_PAYLOAD;
      m_key_idx = 2'd0;
      push_res(KIND_HEADER, 8'h00, 1'b0, ERR_NONE);
    end else begin
      m_phase = ST_HEADER;
      push_res(KIND_EMPTY, 8'h00, 1'b1, ERR_NONE);
    end
  endtask

  // Advance the parser model by one accepted byte.
  task automatic predict_deframe(input logic [7:0] b, input logic [1:0] link);
    logic [3:0] op;
    logic [6:0] len;
    logic [7:0] v;
    if (m_stopped) return;
    if (link == LINK_CLOSED) begin
      model_fail(ERR_CLOSED);
      return;
    end
    if (link != LINK_BYTE) begin
      model_fail(ERR_FAULT);
      return;
    end
    case (m_phase)
      ST_LEN: begin
        len = b[6:0];
        op  = m_op;
        if (!(b & TOP_BIT) && server_cfg) model_fail(ERR_UNMASKED);
        else if (len > LEN_MAX_SHORT && op >= 4'd8) model_fail(ERR_CTRL_LONG);
        else if ((op >= 4'd3 && op <= 4'd7) || op >= 4'd11) model_fail(ERR_RSV_OPCODE);
        else if (len <= LEN_MAX_SHORT) begin
          m_remain = {57'd0, len};
          model_len_done();
        end else begin
          m_remain   = 64'd0;
          m_ext_left = (len == LEN_EXT16) ? 4'd2 : 4'd8;
          m_phase    = ST_EXT;
          push_res(KIND_HEADER, 8'h00, 1'b0, ERR_NONE);
        end
      end
      ST_EXT: begin
        m_remain   = {m_remain[55:0], b};
        m_ext_left = m_ext_left - 4'd1;
        if (m_ext_left == 4'd0) model_len_done();
        else push_res(KIND_HEADER, 8'h00, 1'b0, ERR_NONE);
      end
      ST_KEY: begin
        m_key      = {m_key[23:0], b};
        m_ext_left = m_ext_left - 4'd1;
        if (m_ext_left != 4'd0) push_res(KIND_HEADER, 8'h00, 1'b0, ERR_NONE);
        else if (m_remain != 64'd0) begin
          m_phase   = ST_PAYLOAD;
          m_key_idx = 2'd0;
          push_res(KIND_HEADER, 8'h00, 1'b0, ERR_NONE);
        end else begin
          m_phase = ST_HEADER;
          push_res(KIND_EMPTY, 8'h00, 1'b1, ERR_NONE);
        end
      end
      ST_PAYLOAD: begin
        v = b;
        if (server_cfg) v = v ^ m_key[(3 - m_key_idx) * 8 +: 8];
        m_key_idx = m_key_idx + 2'd1;
        m_remain  = m_remain - 64'd1;
        if (m_remain == 64'd0) m_phase = ST_HEADER;
        push_res(KIND_PAYLOAD, v, m_remain == 64'd0, ERR_NONE);
      end
      default: begin
        op    = b[3:0];
        m_fin = b[7];
        if (b & RSV_BITS) model_fail(ERR_RSV);
        else if (!m_fin && op >= 4'd8) model_fail(ERR_FRAG_CTRL);
        else if (op != OP_CONT && m_frag_op != 4'd0 && (!m_fin || op < 4'd8))
          model_fail(ERR_IN_FRAGMENT);
        else if (op == OP_CONT && m_frag_op == 4'd0) model_fail(ERR_NO_START);
        else begin
          if (op != OP_CONT) begin
            if (!m_fin) m_frag_op = op;
            m_op = op;
          end else begin
            m_op = m_frag_op;
            if (m_fin) m_frag_op = 4'd0;
          end
          m_phase = ST_LEN;
          push_res(KIND_HEADER, 8'h00, 1'b0, ERR_NONE);
        end
      end
    endcase
  endtask

  // ---------------------------------------------------------------- stimulus

  task automatic push_byte(input logic [7:0] b, input logic [1:0] link = LINK_BYTE);
    wsd_item_t it;
    it.data = b;
    it.link = link;
    byte_queue.push_back(it);
  endtask

  // Queue one frame; form picks the length encoding (0 short, 1 ext16, 2 ext64).
  task automatic push_frame(input logic fin, input logic [3:0] op, input int unsigned len,
                            input int form);
    logic mbit;
    mbit = server_cfg ? 1'b1 : 1'($urandom_range(0, 1));
    push_byte({fin, 3'b000, op});
    if (form == 0) push_byte({mbit, 7'(len)});
    else if (form == 1) begin
      push_byte({mbit, LEN_EXT16});
      push_byte(8'(len >> 8));
      push_byte(8'(len));
    end else begin
      push_byte({mbit, LEN_EXT64});
      for (int i = 7; i >= 0; i--) push_byte(i >= 4 ? 8'h00 : 8'(len >> (8 * i)));
    end
    if (server_cfg) repeat (4) push_byte(8'($urandom));
    repeat (len) push_byte(8'($urandom));
  endtask

  // Random data frame length and encoding; mostly short payloads.
  task automatic pick_len(output int unsigned len, output int form);
    int r;
    r = $urandom_range(0, 99);
    len  = (r < 85) ? $urandom_range(0, 8) : $urandom_range(0, 125);
    form = 0;
    r = $urandom_range(0, 99);
    if (r >= 85 && r < 93) form = 1;
    else if (r >= 93) form = 2;
    if (form != 0 && $urandom_range(0, 3) == 0) len = 0;
  endtask

  task automatic push_control();
    logic [3:0] op;
    op = 4'(8 + $urandom_range(0, 2));
    push_frame(1'b1, op, $urandom_range(0, 3) == 0 ? $urandom_range(0, 125)
                                                   : $urandom_range(0, 6), 0);
  endtask

  // One well-formed message: single frame, lone control frame, or fragments.
  task automatic push_message();
    int r;
    int unsigned len;
    int form;
    logic [3:0] op;
    r  = $urandom_range(0, 99);
    op = $urandom_range(0, 1) ? OP_TEXT : OP_BINARY;
    if (r < 30) begin
      pick_len(len, form);
      push_frame(1'b1, op, len, form);
    end else if (r < 50) begin
      push_control();
    end else begin
      pick_len(len, form);
      push_frame(1'b0, op, len, form);
      repeat ($urandom_range(0, 3)) begin
        if ($urandom_range(0, 2) == 0) push_control();
        pick_len(len, form);
        push_frame(1'b0, OP_CONT, len, form);
      end
      if ($urandom_range(0, 2) == 0) push_control();
      pick_len(len, form);
      push_frame(1'b1, OP_CONT, len, form);
    end
  endtask

  task automatic apb_write(input logic [2:0] addr, input logic [31:0] data);
    @(posedge clk);
    psel    <= 1'b1;
    pwrite  <= 1'b1;
    penable <= 1'b0;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic set_server(input bit on);
    apb_write({REG_SERVER_MODE[0], 2'b00}, {31'd0, on});
    server_cfg = on;
  endtask

  // Hold the sender until the stream is drained and every result is in.
  task automatic drain();
    do @(posedge clk);
    while (byte_queue.size() != 0 || in_if.valid || expected_res.size() != 0);
    repeat (10) @(posedge clk);
  endtask

  // Close the run with one error; the block must then ignore everything.
  task automatic push_final_error();
    int sel;
    logic [3:0] op;
    sel = $urandom_range(0, 9);
    case (sel)
      0: push_byte({1'($urandom_range(0, 1)), 3'($urandom_range(1, 7)), 4'($urandom)});
      1: push_byte({1'b0, 3'b000, 4'($urandom_range(8, 15))});
      2: begin
        push_frame(1'b0, OP_TEXT, $urandom_range(0, 3), 0);
        push_byte({1'($urandom_range(0, 1)), 3'b000, 4'($urandom_range(1, 2))});
      end
      3: push_byte({1'($urandom_range(0, 1)), 3'b000, OP_CONT});
      4: begin
        push_byte({1'b1, 3'b000, OP_TEXT});
        push_byte({1'b0, 7'($urandom)});
      end
      5: begin
        push_byte({1'b1, 3'b000, OP_PING});
        push_byte({1'($urandom_range(0, 1)) | server_cfg, 6'h3f,
                   1'($urandom_range(0, 1))});
      end
      6: begin
        op = $urandom_range(0, 1) ? 4'($urandom_range(3, 7)) : 4'($urandom_range(11, 15));
        push_byte({1'b1, 3'b000, op});
        push_byte({1'($urandom_range(0, 1)) | server_cfg, 7'($urandom)});
      end
      default: begin
        // huge 64-bit length, a few payload bytes, then a link event
        push_byte({1'b1, 3'b000, OP_BINARY});
        push_byte({1'b1, LEN_EXT64});
        push_byte(8'($urandom) | TOP_BIT);
        repeat (7) push_byte(8'($urandom));
        if (server_cfg) repeat (4) push_byte(8'($urandom));
        repeat ($urandom_range(0, 5)) push_byte(8'($urandom));
        push_byte(8'($urandom), sel == 7 ? LINK_CLOSED :
                                 sel == 8 ? LINK_FAULT : 2'd3);
      end
    endcase
    repeat (6) push_byte(8'($urandom), 2'($urandom));
  endtask

  // ----------------------------------------------------------------- driver

  always @(posedge clk) begin
    if (rst) begin
      in_if.valid <= 1'b0;
      send_gap    <= 0;
    end else if (!in_if.valid || in_if.ready) begin
      if (send_gap > 0) begin
        send_gap    <= send_gap - 1;
        in_if.valid <= 1'b0;
      end else if (byte_queue.size() != 0) begin
        in_if.valid       <= 1'b1;
        in_if.byte_in     <= byte_queue[0].data;
        in_if.link_status <= byte_queue[0].link;
        void'(byte_queue.pop_front());
        send_gap <= idle_on ? rand_gap() : 0;
      end else begin
        in_if.valid <= 1'b0;
      end
    end
  end

  // Predict on every accepted input transaction.
  always @(posedge clk) begin
    if (!rst && in_if.valid && in_if.ready) predict_deframe(in_if.byte_in, in_if.link_status);
  end

  // Receiver back-pressure: random stalls, none when idling is off.
  always @(posedge clk) begin
    if (rst) begin
      out_if.ready <= 1'b0;
      recv_stall   <= 0;
    end else if (recv_stall > 0) begin
      recv_stall   <= recv_stall - 1;
      out_if.ready <= 1'b0;
    end else begin
      out_if.ready <= 1'b1;
      if (idle_on && $urandom_range(0, 3) == 0) recv_stall <= rand_gap();
    end
  end

  // ----------------------------------------------------------------- monitor

  always @(posedge clk) begin
    deframe_res_t e;
    if (!rst && out_if.valid && out_if.ready) begin
      if (expected_res.size() == 0) begin
        report("unexpected result kind", -1, out_if.kind);
      end else begin
        e = expected_res.pop_front();
        if (out_if.kind !== e.kind) report("kind", e.kind, out_if.kind);
        if (out_if.payload_byte !== e.pbyte) report("payload_byte", e.pbyte, out_if.payload_byte);
        if (out_if.frame_opcode !== e.opcode) report("frame_opcode", e.opcode, out_if.frame_opcode);
        if (out_if.frame_fin !== e.fin) report("frame_fin", e.fin, out_if.frame_fin);
        if (out_if.last_of_frame !== e.last) report("last_of_frame", e.last, out_if.last_of_frame);
        if (out_if.error_code !== e.code) report("error_code", e.code, out_if.error_code);
      end
    end
  end

  // ------------------------------------------------------------------ main

  initial begin
    clk = 1'b0;
    rst = 1'b1;
    psel = 1'b0;
    penable = 1'b0;
    pwrite = 1'b0;
    paddr = '0;
    pwdata = '0;
    in_if.valid = 1'b0;
    in_if.byte_in = '0;
    in_if.link_status = LINK_BYTE;
    out_if.ready = 1'b0;
    err_count = 0;
    idle_on = 1'b0;
    server_cfg = 1'b0;
    m_phase = ST_HEADER;
    m_fin = 1'b0;
    m_op = 4'd0;
    m_frag_op = 4'd0;
    m_remain = '0;
    m_ext_left = '0;
    m_key = '0;
    m_key_idx = '0;
    m_stopped = 1'b0;
    repeat (11) @(posedge clk);
    rst <= 1'b0;

    // Directed: empty frames, short and extended lengths, byte extremes.
    set_server(1'b0);
    push_frame(1'b1, OP_TEXT, 0, 0);
    push_frame(1'b1, OP_PING, 1, 0);
    push_frame(1'b1, OP_BINARY, 0, 1);
    push_byte(8'h82); push_byte(8'h02); push_byte(8'hff); push_byte(8'h00);
    push_frame(1'b1, OP_CLOSE, 0, 0);
    drain();
    set_server(1'b1);
    push_frame(1'b1, OP_TEXT, 0, 0);
    push_frame(1'b1, OP_BINARY, 5, 2);
    drain();

    // Random phases alternating mode, idling on in most of them.
    for (int ph = 0; ph < 6; ph++) begin
      set_server(ph[0]);
      idle_on = (ph != 2);
      while (byte_queue.size() < 100) push_message();
      drain();
    end

    idle_on = 1'b1;
    set_server(1'($urandom_range(0, 1)));
    push_message();
    push_final_error();
    drain();
    repeat (20) @(posedge clk);

    if (err_count == 0 && expected_res.size() == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

  // Watchdog.
  initial begin
    #5ms;
    $display("DONE: errors detected");
    $finish;
  end

endmodule
